@@ design/plpa_pkg.sv @@
// ----------------------------------------------------------------------------
// plpa_pkg
// Shared types and constants for the point-light pixel accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package plpa_pkg;

  localparam int TILE_PIXELS_DEF = 16;
  localparam int SUB_PIXELS_DEF  = 16;
  localparam int FADE_STEPS_DEF  = 48;

  localparam int POS_W   = 16;
  localparam int REACH_W = 12;
  localparam int COL_W   = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // widths sized for the largest fade step count (255)
  localparam int DIST_W = 24;          // squared distance within reach
  localparam int FSQ_W  = 16;          // fade steps squared
  localparam int LHS_W  = DIST_W + FSQ_W;
  localparam int ROOT_W = LHS_W / 2;
  localparam int K_W    = 8;
  localparam int PROD_W = 16;          // share * colour
  localparam int RCP_SH = 25;
  localparam int RCP_W  = 25;

  localparam logic [IDX_W-1:0] REG_SOURCE_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_REACH       = 3'd2;
  localparam logic [IDX_W-1:0] REG_LIGHT_RED   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIGHT_GREEN = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIGHT_BLUE  = 3'd5;

  typedef struct packed {
    logic [7:0] tile_x;
    logic [7:0] tile_y;
    logic [3:0] sub_x;
    logic [3:0] sub_y;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       lit;
  } out_word_t;

  typedef struct packed {
    logic [2:0][COL_W-1:0] cur;
    logic                  ok;
  } side_t;

endpackage

`default_nettype wire

@@ design/point_light_pixel_accumulate_top.sv @@
// ----------------------------------------------------------------------------
// point_light_pixel_accumulate_top
// Adds the light of one point source, with linear falloff, to one pixel.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | in_word_i  (plpa_pkg::in_word_t)
// out     | output    | out_valid_o/out_ready_i | out_word_o (plpa_pkg::out_word_t)
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One word per cycle while the output is not stalled, through a single pipeline:
// position, squares, distance test, scaling, 20 square-root digit stages, 8
// quotient stages and 3 colour stages. The whole pipe advances when the last
// stage is empty or taken, so a stall holds every stage. Reset clears valid
// bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module point_light_pixel_accumulate_top #(
  parameter int TILE_PIXELS = plpa_pkg::TILE_PIXELS_DEF,
  parameter int SUB_PIXELS  = plpa_pkg::SUB_PIXELS_DEF,
  parameter int FADE_STEPS  = plpa_pkg::FADE_STEPS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  plpa_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output plpa_pkg::out_word_t              out_word_o,
  input  wire                              cfg_we_i,
  input  wire  [plpa_pkg::IDX_W-1:0]       cfg_idx_i,
  input  wire  [plpa_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int POS_W  = plpa_pkg::POS_W;
  localparam int LHS_W  = plpa_pkg::LHS_W;
  localparam int ROOT_W = plpa_pkg::ROOT_W;
  localparam int K_W    = plpa_pkg::K_W;
  localparam int DIST_W = plpa_pkg::DIST_W;
  localparam int PROD_W = plpa_pkg::PROD_W;
  localparam int RCP_SH = plpa_pkg::RCP_SH;
  localparam int RCP_W  = plpa_pkg::RCP_W;
  localparam int T_W    = PROD_W + RCP_W;
  localparam int REM_W  = ROOT_W + 2;

  localparam int SQ_N   = ROOT_W;
  localparam int DV_N   = K_W;
  localparam int ST_SQ0 = 4;
  localparam int ST_DV0 = ST_SQ0 + SQ_N;
  localparam int ST_V   = ST_DV0 + DV_N + 1;
  localparam int NST    = ST_V + 2;

  localparam logic [plpa_pkg::FSQ_W-1:0] FSQ = plpa_pkg::FSQ_W'(FADE_STEPS * FADE_STEPS);
  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RCP_SH) / FADE_STEPS);
  localparam logic [POS_W-1:0] HALF_TILE = POS_W'(TILE_PIXELS / 2);

  // configuration
  logic [POS_W-1:0]              src_x_q, src_y_q;
  logic [plpa_pkg::REACH_W-1:0]  reach_q;
  logic [2:0][plpa_pkg::COL_W-1:0] light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q  <= '0;
      src_y_q  <= '0;
      reach_q  <= 12'd64;
      light_q  <= {3{8'd255}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plpa_pkg::REG_SOURCE_X:    src_x_q    <= cfg_data_i;
        plpa_pkg::REG_SOURCE_Y:    src_y_q    <= cfg_data_i;
        plpa_pkg::REG_REACH:       reach_q    <= cfg_data_i[11:0];
        plpa_pkg::REG_LIGHT_RED:   light_q[2] <= cfg_data_i[7:0];
        plpa_pkg::REG_LIGHT_GREEN: light_q[1] <= cfg_data_i[7:0];
        plpa_pkg::REG_LIGHT_BLUE:  light_q[0] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [DIST_W-1:0] r2;
  assign r2 = DIST_W'(reach_q) * DIST_W'(reach_q);

  // pipeline control
  logic               en;
  logic [NST:1]       valid_q;
  plpa_pkg::side_t    side_q [1:NST-1];
  plpa_pkg::side_t    side_in;

  assign en         = !valid_q[NST] || out_ready_i;
  assign in_ready_o = en;

  assign side_in.cur = {in_word_i.cur_red, in_word_i.cur_green, in_word_i.cur_blue};
  assign side_in.ok  = ({28'd0, in_word_i.sub_x} < 32'(SUB_PIXELS)) &&
                       ({28'd0, in_word_i.sub_y} < 32'(SUB_PIXELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-1:1], in_valid_i};
    end
  end

  // stage 1: position and absolute differences
  logic [POS_W-1:0] px, py, adx_q, ady_q;
  assign px = POS_W'(POS_W'(in_word_i.tile_x) * POS_W'(TILE_PIXELS)) - HALF_TILE
              + POS_W'(in_word_i.sub_x);
  assign py = POS_W'(POS_W'(in_word_i.tile_y) * POS_W'(TILE_PIXELS)) - HALF_TILE
              + POS_W'(in_word_i.sub_y);

  // stage 2: squares, stage 3: distance test, stage 4: scaled distance
  logic [2*POS_W-1:0] dx2_q, dy2_q;
  logic [2*POS_W:0]   dsum;
  logic [DIST_W-1:0]  d_q;
  logic [LHS_W-1:0]   lhs_q;

  assign dsum = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q     <= (px >= src_x_q) ? px - src_x_q : src_x_q - px;
      ady_q     <= (py >= src_y_q) ? py - src_y_q : src_y_q - py;
      side_q[1] <= side_in;
      dx2_q     <= adx_q * adx_q;
      dy2_q     <= ady_q * ady_q;
      side_q[2] <= side_q[1];
      d_q       <= dsum[DIST_W-1:0];
      side_q[3].cur <= side_q[2].cur;
      side_q[3].ok  <= side_q[2].ok && (dsum < (2*POS_W+1)'(r2));
      lhs_q     <= LHS_W'(FSQ) * LHS_W'(d_q);
      side_q[4] <= side_q[3];
      for (int i = ST_SQ0 + 1; i <= NST - 1; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // square root, one result bit per stage
  logic [REM_W-1:0]  sq_rem_q  [0:SQ_N];
  logic [ROOT_W-1:0] sq_root_q [0:SQ_N];
  logic [LHS_W-1:0]  sq_x_q    [0:SQ_N];

  assign sq_rem_q[0]  = '0;
  assign sq_root_q[0] = '0;
  assign sq_x_q[0]    = lhs_q;

  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    logic [REM_W-1:0] rem_n, trial;
    assign rem_n = {sq_rem_q[s][REM_W-3:0], sq_x_q[s][LHS_W-1 -: 2]};
    assign trial = {sq_root_q[s], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x_q[s+1] <= {sq_x_q[s][LHS_W-3:0], 2'b00};
        if (rem_n >= trial) begin
          sq_rem_q[s+1]  <= rem_n - trial;
          sq_root_q[s+1] <= {sq_root_q[s][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q[s+1]  <= rem_n;
          sq_root_q[s+1] <= {sq_root_q[s][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // root divided by reach, one quotient bit per stage
  logic [ROOT_W-1:0] dv_rem_q [0:DV_N];
  logic [K_W-1:0]    dv_q_q   [0:DV_N];

  assign dv_rem_q[0] = sq_root_q[SQ_N];
  assign dv_q_q[0]   = '0;

  for (genvar s = 0; s < DV_N; s++) begin : g_div
    logic [ROOT_W-1:0] dvs;
    assign dvs = ROOT_W'(reach_q) << (DV_N - 1 - s);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (dv_rem_q[s] >= dvs) begin
          dv_rem_q[s+1] <= dv_rem_q[s] - dvs;
          dv_q_q[s+1]   <= {dv_q_q[s][K_W-2:0], 1'b1};
        end else begin
          dv_rem_q[s+1] <= dv_rem_q[s];
          dv_q_q[s+1]   <= {dv_q_q[s][K_W-2:0], 1'b0};
        end
      end
    end
  end

  // colour: share * colour, reciprocal multiply, correct and saturate; unlit pixels pass unchanged
  logic [K_W-1:0]             share;
  logic [2:0][PROD_W-1:0]     v_q, v2_q;
  logic [2:0][T_W-1:0]        t_q;
  logic [2:0][plpa_pkg::COL_W-1:0] res_q;
  logic                       lit_q;

  assign share = K_W'(FADE_STEPS) - dv_q_q[DV_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        v_q[c]  <= PROD_W'(share) * PROD_W'(light_q[c]);
        v2_q[c] <= v_q[c];
        t_q[c]  <= T_W'(v_q[c]) * T_W'(RCP);
      end
    end
  end

  logic [2:0][plpa_pkg::COL_W-1:0] res_d;
  always_comb begin
    logic [PROD_W-1:0] q0;
    logic [23:0]       rm;
    logic [PROD_W-1:0] q;
    logic [PROD_W:0]   sum;
    for (int c = 0; c < 3; c++) begin
      q0  = t_q[c][RCP_SH +: PROD_W];
      rm  = 24'(v2_q[c]) - 24'(q0) * 24'(FADE_STEPS);
      q   = (rm >= 24'(FADE_STEPS)) ? q0 + PROD_W'(1) : q0;
      sum = (PROD_W+1)'(side_q[NST-1].cur[c]) + (PROD_W+1)'(q);
      if (!side_q[NST-1].ok) begin
        res_d[c] = side_q[NST-1].cur[c];
      end else if (sum > (PROD_W+1)'(255)) begin
        res_d[c] = 8'd255;
      end else begin
        res_d[c] = sum[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      lit_q <= side_q[NST-1].ok;
    end
  end

  assign out_valid_o          = valid_q[NST];
  assign out_word_o.out_red   = res_q[2];
  assign out_word_o.out_green = res_q[1];
  assign out_word_o.out_blue  = res_q[0];
  assign out_word_o.lit       = lit_q;

endmodule

`default_nettype wire

@@ tb/plpa_checker.sv @@
// ----------------------------------------------------------------------------
// plpa_checker
// Watches the pixel channels and the register port of the point-light
// accumulator. For each accepted input word it predicts the output word and
// compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module plpa_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  plpa_pkg::in_word_t        in_word_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  plpa_pkg::out_word_t       out_word_i,
  input  logic                      cfg_we_i,
  input  logic [plpa_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [plpa_pkg::CFG_W-1:0] cfg_data_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        lit_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] src_x, src_y;
  logic [11:0] reach;
  logic [7:0]  col_r, col_g, col_b;
  plpa_pkg::out_word_t lit_q[$];

  function automatic logic [15:0] pixel_pos(logic [7:0] tile, logic [3:0] sub);
    return 16'(tile * plpa_pkg::TILE_PIXELS_DEF - plpa_pkg::TILE_PIXELS_DEF / 2 + sub);
  endfunction

  function automatic logic [7:0] add_light(logic [7:0] cur, logic [7:0] col, int share);
    int sum;
    sum = cur + (share * col) / plpa_pkg::FADE_STEPS_DEF;
    return (sum > 255) ? 8'd255 : 8'(sum);
  endfunction

  function automatic plpa_pkg::out_word_t predict_word(plpa_pkg::in_word_t w);
    longint dx, dy, d2, r, lhs;
    int k;
    plpa_pkg::out_word_t o;
    dx = longint'(pixel_pos(w.tile_x, w.sub_x)) - longint'(src_x);
    dy = longint'(pixel_pos(w.tile_y, w.sub_y)) - longint'(src_y);
    d2 = dx * dx + dy * dy;
    r  = reach;
    o  = '{w.cur_red, w.cur_green, w.cur_blue, 1'b0};
    if (w.sub_x < plpa_pkg::SUB_PIXELS_DEF && w.sub_y < plpa_pkg::SUB_PIXELS_DEF &&
        d2 < r * r) begin
      lhs = longint'(plpa_pkg::FADE_STEPS_DEF) * plpa_pkg::FADE_STEPS_DEF * d2;
      k = 0;
      while (k + 1 < plpa_pkg::FADE_STEPS_DEF &&
             (longint'(k + 1) * r) * (longint'(k + 1) * r) <= lhs)
        k++;
      o.out_red   = add_light(w.cur_red, col_r, plpa_pkg::FADE_STEPS_DEF - k);
      o.out_green = add_light(w.cur_green, col_g, plpa_pkg::FADE_STEPS_DEF - k);
      o.out_blue  = add_light(w.cur_blue, col_b, plpa_pkg::FADE_STEPS_DEF - k);
      o.lit       = 1'b1;
    end
    return o;
  endfunction

  assign pending_o = lit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    plpa_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      src_x <= '0; src_y <= '0; reach <= 12'd64;
      col_r <= 8'd255; col_g <= 8'd255; col_b <= 8'd255;
      lit_q.delete();
      errors_o <= 0;
      lit_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) lit_q.push_back(predict_word(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (lit_q.size() == 0) begin
          $error("output word with nothing expected: %h", out_word_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = lit_q.pop_front();
          if (out_word_i.lit) lit_count_o <= lit_count_o + 1;
          if (out_word_i.out_red !== exp_w.out_red)
            $error("out_red: expected %0d, got %0d", exp_w.out_red, out_word_i.out_red);
          if (out_word_i.out_green !== exp_w.out_green)
            $error("out_green: expected %0d, got %0d", exp_w.out_green, out_word_i.out_green);
          if (out_word_i.out_blue !== exp_w.out_blue)
            $error("out_blue: expected %0d, got %0d", exp_w.out_blue, out_word_i.out_blue);
          if (out_word_i.lit !== exp_w.lit)
            $error("lit: expected %0d, got %0d", exp_w.lit, out_word_i.lit);
          if (out_word_i !== exp_w) errors_o <= errors_o + 1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          plpa_pkg::REG_SOURCE_X:    src_x <= cfg_data_i;
          plpa_pkg::REG_SOURCE_Y:    src_y <= cfg_data_i;
          plpa_pkg::REG_REACH:       reach <= cfg_data_i[11:0];
          plpa_pkg::REG_LIGHT_RED:   col_r <= cfg_data_i[7:0];
          plpa_pkg::REG_LIGHT_GREEN: col_g <= cfg_data_i[7:0];
          plpa_pkg::REG_LIGHT_BLUE:  col_b <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives pixel words and register settings into the point-light accumulator
// under random idling on both channels; plpa_checker does the checking.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;
  localparam int DRAIN = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_ready;
  plpa_pkg::in_word_t in_word = '0;
  logic out_valid, out_ready = 1'b0;
  plpa_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [plpa_pkg::IDX_W-1:0] cfg_idx = '0;
  logic [plpa_pkg::CFG_W-1:0] cfg_data = '0;
  int errors, pending, lit_count, cycles = 0, sent = 0;
  bit quiet = 0;
  logic [15:0] cur_sx = 0, cur_sy = 0;
  logic [11:0] cur_reach = 64;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  point_light_pixel_accumulate_top uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  plpa_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .lit_count_o(lit_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls in bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send(plpa_pkg::in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [plpa_pkg::IDX_W-1:0] idx,
                           logic [plpa_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    if (idx == plpa_pkg::REG_SOURCE_X) cur_sx = val;
    if (idx == plpa_pkg::REG_SOURCE_Y) cur_sy = val;
    if (idx == plpa_pkg::REG_REACH) cur_reach = val[11:0];
  endtask

  task automatic configure(int sx, int sy, int rch, int r, int g, int b);
    write_reg(plpa_pkg::REG_SOURCE_X, 16'(sx));
    write_reg(plpa_pkg::REG_SOURCE_Y, 16'(sy));
    write_reg(plpa_pkg::REG_REACH, 16'(rch));
    write_reg(plpa_pkg::REG_LIGHT_RED, 16'(r));
    write_reg(plpa_pkg::REG_LIGHT_GREEN, 16'(g));
    write_reg(plpa_pkg::REG_LIGHT_BLUE, 16'(b));
  endtask

  function automatic plpa_pkg::in_word_t make_pixel(int px, int py);
    plpa_pkg::in_word_t w;
    w.tile_x = 8'((px + 8) >> 4);
    w.sub_x  = 4'(px + 8);
    w.tile_y = 8'((py + 8) >> 4);
    w.sub_y  = 4'(py + 8);
    w.cur_red = 8'($urandom); w.cur_green = 8'($urandom); w.cur_blue = 8'($urandom);
    return w;
  endfunction

  task automatic random_words(int n);
    int r;
    plpa_pkg::in_word_t w;
    repeat (n) begin
      r = cur_reach;
      if ($urandom_range(0, 3) == 0) begin
        w = {$urandom, 16'($urandom)};
      end else begin
        w = make_pixel(int'(cur_sx) + $urandom_range(0, 2 * r) - r,
                       int'(cur_sy) + $urandom_range(0, 2 * r) - r);
        if ($urandom_range(0, 4) == 0) w.cur_red = 8'hff;
        if ($urandom_range(0, 4) == 0) w.cur_blue = 8'h00;
      end
      send(w);
    end
  endtask

  initial begin
    plpa_pkg::in_word_t w;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: source at origin, reach 64, white light
    w = make_pixel(0, 0); w.cur_red = 0; w.cur_green = 255; w.cur_blue = 128;
    send(w);
    w = make_pixel(63, 0); send(w);
    w = make_pixel(64, 0); send(w);
    w = make_pixel(0, 63); send(w);
    w = make_pixel(45, 45); send(w);
    w = '0; send(w);
    w = '1; send(w);
    w = make_pixel(-8, -8); w.cur_red = 255; w.cur_green = 0; w.cur_blue = 1;
    send(w);
    w = make_pixel(10, 3); w.cur_red = 250; w.cur_green = 250; w.cur_blue = 250;
    send(w);
    settle();

    configure(2000, 1000, 4095, 0, 128, 255);
    cfg_we <= 1'b0;
    w = make_pixel(2000, 1000); w.cur_red = 255; send(w);
    w = make_pixel(4087, 4087); send(w);
    random_words(75);
    settle();

    configure(4087, 4087, 1, 255, 255, 255);
    cfg_we <= 1'b0;
    w = make_pixel(4087, 4087); send(w);
    w = make_pixel(4086, 4087); send(w);
    random_words(70);
    settle();

    configure(65535, 0, 300, 17, 200, 3);
    cfg_we <= 1'b0;
    random_words(75);
    settle();

    // zero reach: nothing is ever lit
    configure(100, 3000, 0, 9, 9, 9);
    cfg_we <= 1'b0;
    w = make_pixel(100, 3000); send(w);
    random_words(60);
    settle();

    // writes past the last register must change nothing
    configure(1500, 1500, 37, 255, 1, 99);
    write_reg(3'd6, 16'hffff);
    write_reg(3'd7, 16'h0000);
    cfg_we <= 1'b0;
    random_words(80);
    settle();

    configure(65535, 65535, 4095, 255, 254, 1);
    write_reg(plpa_pkg::REG_SOURCE_X, 16'd3000);
    write_reg(plpa_pkg::REG_SOURCE_Y, 16'd200);
    cfg_we <= 1'b0;
    quiet = 1;
    random_words(90);
    settle();

    $display("Sent %0d pixel words over seven light settings; %0d came back lit.",
             sent, lit_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ point_light_pixel_accumulate_top.f @@
design/plpa_pkg.sv
design/point_light_pixel_accumulate_top.sv
tb/plpa_checker.sv
tb/testbench.sv
